// ===== rtl/debug_packet_receiver_defines.svh =====
// Assertion macros for the debug packet receiver.
// Both macros expect clk_i and rst_ni in scope at the point of use.
`ifndef DEBUG_PACKET_RECEIVER_DEFINES_SVH
`define DEBUG_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define DPR_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dpr: invariant violated");

// Consequent holds in the cycle after the antecedent.
`define DPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpr: next-cycle check violated");

`else

`define DPR_ASSERT_NOW(lbl, expr)
`define DPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/dpr_pkg.sv =====
package dpr_pkg;

  localparam logic [7:0] AckByte   = 8'h2B;  // '+'
  localparam logic [7:0] StartByte = 8'h24;  // '$'
  localparam logic [7:0] HashByte  = 8'h23;  // '#'
  localparam logic [3:0] NibbleMask = 4'hF;

  typedef enum logic [2:0] {
    PH_ACK   = 3'd0,
    PH_START = 3'd1,
    PH_DATA  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LOW   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_NO_ACK   = 2'd2,
    ST_BAD_START = 2'd3
  } status_e;

  // Hex digit to value; a non-hex byte keeps its raw value.
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
    return v;
  endfunction

endpackage

// ===== rtl/debug_packet_receiver.sv =====
// Debug packet receiver: one received byte per request, zero or one result.
// A result appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a result is
// held in the output register and the consumer stalls it.
// Reset (rst_ni low, async): phase waits for '+', sum and digit flag cleared.
`include "debug_packet_receiver_defines.svh"

module debug_packet_receiver import dpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_payload_o,
  output logic       is_verdict_o,
  output logic [1:0] status_o
);

  // Protocol state
  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic       hi_ok_q, hi_ok_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       is_payload_q, is_verdict_q;
  logic [1:0] status_q;

  // Result of the byte being accepted
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_pay, res_verd;
  status_e    res_status;

  logic       accept;
  logic [7:0] digit;
  logic       digit_hi_match, digit_lo_match;

  // The output register is free when empty or being drained this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign digit          = digit_value(rx_byte_i);
  assign digit_hi_match = (digit == {4'd0, sum_q[7:4] & NibbleMask});
  assign digit_lo_match = (digit == {4'd0, sum_q[3:0] & NibbleMask});

  // Phase machine: next state and the result for this byte.
  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    hi_ok_d    = hi_ok_q;
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_pay    = 1'b0;
    res_verd   = 1'b0;
    res_status = ST_OK;
    case (phase_q)
      PH_START: begin
        if (rx_byte_i == StartByte) begin
          sum_d   = 8'd0;
          phase_d = PH_DATA;
        end else begin
          phase_d    = PH_ACK;
          res_valid  = 1'b1;
          res_verd   = 1'b1;
          res_status = ST_BAD_START;
        end
      end
      PH_DATA: begin
        if (rx_byte_i == HashByte) begin
          phase_d = PH_HIGH;
        end else begin
          sum_d     = sum_q + rx_byte_i;  // wraps mod 256
          res_valid = 1'b1;
          res_byte  = rx_byte_i;
          res_pay   = 1'b1;
        end
      end
      PH_HIGH: begin
        hi_ok_d = digit_hi_match;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        phase_d    = PH_ACK;
        res_valid  = 1'b1;
        res_verd   = 1'b1;
        res_status = (hi_ok_q && digit_lo_match) ? ST_OK : ST_BAD_SUM;
      end
      default: begin
        // waiting for acknowledge
        if (rx_byte_i == AckByte) begin
          phase_d = PH_START;
        end else begin
          phase_d    = PH_ACK;
          res_valid  = 1'b1;
          res_verd   = 1'b1;
          res_status = ST_NO_ACK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ACK;
      sum_q   <= 8'd0;
      hi_ok_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      hi_ok_q <= hi_ok_d;
    end
  end

  // Output valid: set by a new result, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_byte_q   <= res_byte;
      is_payload_q <= res_pay;
      is_verdict_q <= res_verd;
      status_q     <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_payload_o = is_payload_q;
  assign is_verdict_o = is_verdict_q;
  assign status_o     = status_q;

  // Checks
  `DPR_ASSERT_NOW(a_one_kind, !out_valid_q || (is_payload_q != is_verdict_q))
  `DPR_ASSERT_NOW(a_pay_fields, !(out_valid_q && is_payload_q) || (status_q == ST_OK))
  `DPR_ASSERT_NOW(a_stall_full, !in_stall_o || out_valid_q)
  `DPR_ASSERT_NEXT(a_low_verdict, accept && (phase_q == PH_LOW),
                   out_valid_q && is_verdict_q && (phase_q == PH_ACK))
  `DPR_ASSERT_NEXT(a_data_pay, accept && (phase_q == PH_DATA) && (rx_byte_i != HashByte),
                   out_valid_q && is_payload_q)

endmodule

// ===== bench/debug_packet_receiver_tb.sv =====
// Bench for the debug packet receiver.
// Bytes go in as requests on the input channel; every result leaving the
// block is checked against a local model of the packet framing, one field
// at a time, oldest expectation first.
module debug_packet_receiver_tb import dpr_pkg::*; ;

  // Cycles the consumer holds off in the long stall test.
  localparam int LongHold = 200;
  // Quiet cycles after the last expected result; the block is one deep.
  localparam int DrainCycles = 4;

  // One expected result, widths as on the result ports.
  typedef struct packed {
    logic [7:0] data;
    logic       payload;
    logic       verdict;
    status_e    st;
  } result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       is_payload_o;
  logic       is_verdict_o;
  logic [1:0] status_o;

  debug_packet_receiver i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_payload_o (is_payload_o),
    .is_verdict_o (is_verdict_o),
    .status_o     (status_o)
  );

  // Local copy of the framing state: where we are in the packet, the
  // payload sum so far and whether the high checksum digit matched.
  phase_e     frame_phase = PH_ACK;
  logic [7:0] payload_sum = 8'h00;
  logic       high_match  = 1'b0;

  result_t    expected_results[$];
  int         failures    = 0;
  int         bytes_sent  = 0;

  // Idle and stall odds, in percent per cycle.
  int         idle_pct    = 0;
  int         stall_pct   = 0;

  // Long hold-off requests: the test bumps the request count, the stall
  // process counts the hold itself. Each counter has a single writer.
  int         hold_requests = 0;
  int         holds_started = 0;
  int         hold_left     = 0;

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // Value a checksum character stands for. Letters of either case are hex;
  // anything else is taken at face value, so 0x00..0x0F match directly.
  function automatic logic [7:0] hex_weight(input logic [7:0] c);
    logic [7:0] w;
    w = c;
    if (c inside {[8'h30:8'h39]}) w = c - 8'h30;
    if (c inside {[8'h41:8'h46]}) w = c - 8'h41 + 8'd10;
    if (c inside {[8'h61:8'h66]}) w = c - 8'h61 + 8'd10;
    return w;
  endfunction

  // Character that encodes nibble n: mostly a hex digit with a random letter
  // case, now and then the raw control byte of the same value.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if ($urandom_range(9) == 0) c = {4'h0, n};
    else if (n < 4'd10) c = 8'h30 + n;
    else if ($urandom_range(1) != 0) c = 8'h41 + n - 8'd10;
    else c = 8'h61 + n - 8'd10;
    return c;
  endfunction

  // Advance the framing model by one accepted byte; queue the result, if any.
  task automatic predict_frame(input logic [7:0] b);
    result_t r;
    logic    emits;
    r     = '{data: 8'h00, payload: 1'b0, verdict: 1'b0, st: ST_OK};
    emits = 1'b0;
    case (frame_phase)
      PH_START: begin
        if (b == StartByte) begin
          payload_sum = 8'h00;
          frame_phase = PH_DATA;
        end else begin
          frame_phase = PH_ACK;
          emits       = 1'b1;
          r.verdict   = 1'b1;
          r.st        = ST_BAD_START;
        end
      end
      PH_DATA: begin
        if (b == HashByte) begin
          frame_phase = PH_HIGH;
        end else begin
          payload_sum = payload_sum + b;
          emits       = 1'b1;
          r.data      = b;
          r.payload   = 1'b1;
        end
      end
      PH_HIGH: begin
        high_match  = (hex_weight(b) == {4'h0, payload_sum[7:4]});
        frame_phase = PH_LOW;
      end
      PH_LOW: begin
        emits     = 1'b1;
        r.verdict = 1'b1;
        if (high_match && hex_weight(b) == {4'h0, payload_sum[3:0]}) r.st = ST_OK;
        else r.st = ST_BAD_SUM;
        frame_phase = PH_ACK;
      end
      default: begin
        // waiting for the acknowledge; stray codes behave the same way
        frame_phase = PH_ACK;
        if (b == AckByte) begin
          frame_phase = PH_START;
        end else begin
          emits     = 1'b1;
          r.verdict = 1'b1;
          r.st      = ST_NO_ACK;
        end
      end
    endcase
    if (emits) expected_results.push_back(r);
  endtask

  // Offer one byte as a request and wait for it to be taken. Random idle
  // cycles come first; valid is only dropped while there is no request.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    predict_frame(b);
  endtask

  // Full packet: '+', '$', payload, '#', two checksum characters.
  // A bad checksum mixes a right digit with random bytes at random.
  task automatic send_packet(input int pay_len, input bit good_sum);
    logic [7:0] b;
    logic [7:0] sum;
    int         k;
    sum = 8'h00;
    send_byte(AckByte);
    send_byte(StartByte);
    for (k = 0; k < pay_len; k++) begin
      do b = 8'($urandom_range(255)); while (b == HashByte);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(HashByte);
    if (good_sum || $urandom_range(1) != 0) send_byte(hex_char(sum[7:4]));
    else send_byte(8'($urandom_range(255)));
    if (good_sum) send_byte(hex_char(sum[3:0]));
    else send_byte(8'($urandom_range(255)));
  endtask

  // Mostly well-formed packets with random content; the rest is line noise
  // and starts that break off after the acknowledge.
  task automatic random_traffic(input int n_bytes);
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_packet($urandom_range(8), $urandom_range(3) != 0);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(AckByte);
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Stop offering, let every expected result come out, then a few cycles.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Hand-picked byte streams: field extremes, every status, both digit
  // cases, raw control bytes as checksum digits, and a sum that wraps.
  task automatic test_directed_framing();
    idle_pct  = 0;
    stall_pct = 0;
    // junk before any acknowledge
    send_byte(8'h00);
    send_byte(8'hFF);
    // acknowledge followed by something other than the start byte
    send_byte(AckByte);
    send_byte(8'h78);
    // sum 0xFF + 0x0B wraps to 0x0A, low digit in lower case
    send_byte(AckByte);
    send_byte(StartByte);
    send_byte(8'hFF);
    send_byte(8'h0B);
    send_byte(HashByte);
    send_byte(8'h30);
    send_byte(8'h61);
    // sum 0x10 matched by raw bytes 0x01 and 0x00
    send_byte(AckByte);
    send_byte(StartByte);
    send_byte(8'h10);
    send_byte(HashByte);
    send_byte(8'h01);
    send_byte(8'h00);
    // empty payload, upper case 'A' on the high digit does not match zero
    send_byte(AckByte);
    send_byte(StartByte);
    send_byte(HashByte);
    send_byte(8'h41);
    send_byte(8'h30);
    wait_drained();
  endtask

  task automatic test_streaming();
    idle_pct  = 0;
    stall_pct = 0;
    random_traffic(250);
    wait_drained();
  endtask

  task automatic test_sparse_sender();
    idle_pct  = 86;
    stall_pct = 0;
    random_traffic(250);
    wait_drained();
  endtask

  task automatic test_slow_consumer();
    idle_pct  = 0;
    stall_pct = 86;
    random_traffic(250);
    wait_drained();
  endtask

  task automatic test_light_idling();
    idle_pct  = 7;
    stall_pct = 7;
    random_traffic(250);
    wait_drained();
  endtask

  // Consumer holds off for a long stretch while a long packet streams in,
  // so the output register fills and the input has to stall.
  task automatic test_long_holdoff();
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests <= hold_requests + 1;
    send_packet(40, 1'b1);
    send_packet(3, 1'b0);
    wait_drained();
  endtask

  // Consumer side: random stalls, or a counted hold when one is requested.
  initial begin : stall_gen
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_started != hold_requests) begin
        holds_started++;
        hold_left = LongHold - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result check: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_byte %0h is_payload %0b is_verdict %0b status %0d",
               out_byte_o, is_payload_o, is_verdict_o, status_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
          failures++;
        end
        if (is_payload_o !== want.payload) begin
          $error("is_payload: expected %0b, got %0b", want.payload, is_payload_o);
          failures++;
        end
        if (is_verdict_o !== want.verdict) begin
          $error("is_verdict: expected %0b, got %0b", want.verdict, is_verdict_o);
          failures++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status_o);
          failures++;
        end
      end
    end
  end

  // Sequence: reset once, then each test in turn.
  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_framing();
    test_streaming();
    test_sparse_sender();
    test_slow_consumer();
    test_light_idling();
    test_long_holdoff();
    if (failures == 0) begin
      $display("PASS debug_packet_receiver");
    end else begin
      $display("FAIL debug_packet_receiver");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #800000;
    $display("FAIL debug_packet_receiver");
    $finish;
  end

endmodule
